// ===== design/ctaa_pkg.sv =====
`timescale 1ns / 1ps
package ctaa_pkg;
   localparam int TableDepthDefault = 32;
   localparam int CfgIdxWidth = 2;
   localparam int CfgDataWidth = 32;
   localparam int ReqUserWidth = 2;
   localparam int ReqDataWidth = 152;
   localparam int RspUserWidth = 3;
   localparam int RspDataWidth = 160;

   typedef enum logic [1:0] {
      CMD_CONNECT    = 2'd0,
      CMD_DISCONNECT = 2'd1,
      CMD_TICK       = 2'd2,
      CMD_NONE       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ACK        = 3'd0,
      KIND_NACK_RANGE = 3'd1,
      KIND_NACK_FULL  = 3'd2,
      KIND_DISC_ACK   = 3'd3,
      KIND_TICK_DONE  = 3'd4
   } kind_type;

   localparam logic [CfgIdxWidth-1:0] CFG_POOL_START = 2'd0;
   localparam logic [CfgIdxWidth-1:0] CFG_POOL_SIZE  = 2'd1;
   localparam logic [CfgIdxWidth-1:0] CFG_EXPIRY     = 2'd2;

   localparam logic [7:0]  ID_NONE = 8'hFF;
   localparam logic [5:0]  COUNT_MAX = 6'd63;
   localparam logic [31:0] EXPIRY_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] pool_start;
      logic [31:0] pool_size;
      logic [31:0] expiry_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  entry_id;
      logic [31:0] range_begin;
      logic [31:0] range_size;
      logic        ta_init;
      logic [15:0] ta_value;
      logic [63:0] echo_key;
      logic [5:0]  expired_count;
   } rsp_type;
endpackage

// ===== design/ctaa_cfg.sv =====
`timescale 1ns / 1ps
module ctaa_cfg
   import ctaa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CfgIdxWidth-1:0]  csr_index,
   input  logic [CfgDataWidth-1:0] csr_wdata,
   output cfg_type                 cfg
);
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pool_start   <= '0;
         cfg_ff.pool_size    <= '0;
         cfg_ff.expiry_limit <= EXPIRY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_POOL_START: cfg_ff.pool_start   <= csr_wdata;
            CFG_POOL_SIZE:  cfg_ff.pool_size    <= csr_wdata;
            CFG_EXPIRY:     cfg_ff.expiry_limit <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule

// ===== design/ctaa_core.sv =====
`timescale 1ns / 1ps
module ctaa_core
   import ctaa_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic [1:0]  in_cmd,
   input  logic [63:0] in_key,
   input  logic [31:0] in_size,
   input  logic [31:0] in_now,
   input  logic [15:0] in_ta,
   input  logic [7:0]  in_claimed,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output rsp_type  rsp
);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] LAST = CW'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_OUTER, ST_INNER, ST_COMMIT, ST_RSP
   } state_type;

   state_type state_ff;
   logic [1:0]  cmd_ff;
   logic [63:0] key_ff;
   logic [31:0] want_ff, now_ff;
   logic [15:0] ta_ff;
   logic [7:0]  claimed_ff;

   logic [TABLE_DEPTH-1:0] act_ff;
   logic [TABLE_DEPTH-1:0] one_ff;
   logic [63:0] key_mem [TABLE_DEPTH];
   logic [31:0] beg_mem [TABLE_DEPTH];
   logic [31:0] siz_mem [TABLE_DEPTH];
   logic [31:0] stm_mem [TABLE_DEPTH];

   logic [CW-1:0] i_ff, j_ff;
   logic          hit_ff, free_ok_ff;
   logic [IW-1:0] hit_idx_ff, free_ff;
   logic [5:0]    cnt_ff;
   logic          ok_ff;
   logic [31:0]   best_ff, cand_ff, next_ff;
   logic          excl_ff;
   logic          fresh_ff;
   logic [IW-1:0] tgt_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   logic [IW-1:0] ii, jj;
   logic [31:0]   lim, jb;
   assign ii  = i_ff[IW-1:0];
   assign jj  = j_ff[IW-1:0];
   assign lim = cfg.pool_start + cfg.pool_size;
   assign jb  = beg_mem[jj];

   logic j_act;
   assign j_act = act_ff[jj] && !(excl_ff && jj == tgt_ff);

   logic [31:0] key_hit_size;
   assign key_hit_size = siz_mem[hit_idx_ff];

   logic renew_ok, search_go;
   assign renew_ok  = !excl_ff && hit_ff && want_ff == key_hit_size;
   assign search_go = cmd_type'(cmd_ff) == CMD_CONNECT && !excl_ff && !renew_ok
                      && (hit_ff || free_ok_ff);

   always_comb begin
      rsp_in = '0;
      priority case (cmd_type'(cmd_ff))
         CMD_DISCONNECT: begin
            rsp_in.kind = KIND_DISC_ACK;
            rsp_in.entry_id = claimed_ff;
            rsp_in.echo_key = key_ff;
         end
         CMD_TICK: begin
            rsp_in.kind = KIND_TICK_DONE;
            rsp_in.expired_count = cnt_ff;
         end
         default: begin
            rsp_in.kind = KIND_NACK_RANGE;
            rsp_in.echo_key = key_ff;
            rsp_in.entry_id = ID_NONE;
            if (renew_ok) begin
               rsp_in.kind = KIND_ACK;
               rsp_in.entry_id = 8'(hit_idx_ff);
               rsp_in.range_begin = beg_mem[hit_idx_ff];
               rsp_in.range_size = want_ff;
               rsp_in.ta_init = !act_ff[hit_idx_ff];
               rsp_in.ta_value = act_ff[hit_idx_ff] ? 16'd0 : ta_ff;
            end else if (!excl_ff && !hit_ff && !free_ok_ff) begin
               rsp_in.kind = KIND_NACK_FULL;
            end else if (excl_ff && ok_ff) begin
               rsp_in.kind = KIND_ACK;
               rsp_in.entry_id = 8'(tgt_ff);
               rsp_in.range_begin = best_ff;
               rsp_in.range_size = want_ff;
               rsp_in.ta_init = fresh_ff;
               rsp_in.ta_value = fresh_ff ? ta_ff : 16'd0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         act_ff   <= '0;
         one_ff   <= '0;
         for (int k = 0; k < TABLE_DEPTH; k++) key_mem[k] <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (req_tvalid) begin
               cmd_ff <= in_cmd; key_ff <= in_key; want_ff <= in_size;
               now_ff <= in_now; ta_ff <= in_ta; claimed_ff <= in_claimed;
               i_ff <= '0; hit_ff <= 1'b0; free_ok_ff <= 1'b0; cnt_ff <= '0;
               excl_ff <= 1'b0;
               if (cmd_type'(in_cmd) != CMD_NONE) state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (key_mem[ii] == key_ff) begin
                  hit_ff <= 1'b1; hit_idx_ff <= ii;
               end
               if (!act_ff[ii] && !free_ok_ff) begin
                  free_ok_ff <= 1'b1; free_ff <= ii;
               end
               if (cmd_type'(cmd_ff) == CMD_TICK && act_ff[ii] && one_ff[ii]
                   && (now_ff - stm_mem[ii]) > cfg.expiry_limit) begin
                  act_ff[ii] <= 1'b0; one_ff[ii] <= 1'b0;
                  if (cnt_ff != COUNT_MAX) cnt_ff <= cnt_ff + 6'd1;
               end
               i_ff <= i_ff + 1'b1;
               if (i_ff == LAST) state_ff <= ST_COMMIT;
            end
            ST_OUTER: begin
               // i_ff == TABLE_DEPTH is the pool start candidate
               if (i_ff == CW'(TABLE_DEPTH)) begin
                  cand_ff <= cfg.pool_start; next_ff <= lim; j_ff <= '0;
                  state_ff <= ST_INNER;
               end else if (act_ff[ii] && !(excl_ff && ii == tgt_ff)) begin
                  cand_ff <= beg_mem[ii] + siz_mem[ii]; next_ff <= lim; j_ff <= '0;
                  state_ff <= ST_INNER;
               end else if (i_ff == LAST) begin
                  state_ff <= ST_COMMIT;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            ST_INNER: begin
               if (j_ff == CW'(TABLE_DEPTH)) begin
                  if ((next_ff - cand_ff) >= want_ff && (!ok_ff || cand_ff < best_ff)) begin
                     ok_ff <= 1'b1; best_ff <= cand_ff;
                  end
                  if (i_ff == CW'(TABLE_DEPTH)) i_ff <= '0;
                  else i_ff <= i_ff + 1'b1;
                  state_ff <= (i_ff == LAST) ? ST_COMMIT : ST_OUTER;
               end else begin
                  if (j_act && jb >= cand_ff && jb < next_ff) next_ff <= jb;
                  j_ff <= j_ff + 1'b1;
               end
            end
            ST_COMMIT: begin
               rsp_ff <= rsp_in;
               if (search_go) begin
                  excl_ff <= 1'b1;
                  tgt_ff <= hit_ff ? hit_idx_ff : free_ff;
                  fresh_ff <= hit_ff ? !act_ff[hit_idx_ff] : 1'b1;
                  ok_ff <= 1'b0; i_ff <= CW'(TABLE_DEPTH);
                  state_ff <= ST_OUTER;
                  if (hit_ff) begin
                     act_ff[hit_idx_ff] <= 1'b0; one_ff[hit_idx_ff] <= 1'b0;
                  end
               end else begin
                  state_ff <= ST_RSP;
                  priority case (cmd_type'(cmd_ff))
                     CMD_DISCONNECT: begin
                        if (hit_ff) begin
                           act_ff[hit_idx_ff] <= 1'b0; one_ff[hit_idx_ff] <= 1'b0;
                        end
                     end
                     CMD_TICK: ;
                     default: begin
                        if (renew_ok) begin
                           act_ff[hit_idx_ff] <= 1'b1; one_ff[hit_idx_ff] <= 1'b1;
                           stm_mem[hit_idx_ff] <= now_ff;
                        end else if (excl_ff && ok_ff) begin
                           act_ff[tgt_ff] <= 1'b1; one_ff[tgt_ff] <= 1'b1;
                           key_mem[tgt_ff] <= key_ff; beg_mem[tgt_ff] <= best_ff;
                           siz_mem[tgt_ff] <= want_ff; stm_mem[tgt_ff] <= now_ff;
                        end
                     end
                  endcase
               end
            end
            ST_RSP: if (rsp_tready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RSP);
   assign rsp        = rsp_ff;
endmodule

// ===== design/client_table_address_allocator_top.sv =====
`timescale 1ns / 1ps
// A connect that runs a range search passes through the scan, commit and outer/inner search
// states and a second commit before its result beat; every other command runs the scan and
// commit states only; command 3 is dropped with no result.
// Throughput: one beat in flight; the next input beat is taken the cycle after the result beat.
// Synchronous active-high reset clears the config, the state, entry flags and stored keys at once.
module client_table_address_allocator_top
   import ctaa_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CfgIdxWidth-1:0]  csr_index,
   input  logic [CfgDataWidth-1:0] csr_wdata,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // cmd
   input  logic [ReqUserWidth-1:0] req_tuser,
   // callsign_key, want_size, now_us, timing_advance, claimed_id
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // kind
   output logic [RspUserWidth-1:0] rsp_tuser,
   // entry_id, range_begin, range_size, ta_init, ta_value, echo_key,
   // expired_count, zero fill
   output logic [RspDataWidth-1:0] rsp_tdata
);
   cfg_type cfg;
   rsp_type rsp;

   ctaa_cfg u_cfg (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata, .cfg
   );

   ctaa_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_core (
      .clock, .reset, .cfg,
      .req_tvalid,
      .req_tready,
      .in_cmd     (req_tuser),
      .in_key     (req_tdata[63:0]),
      .in_size    (req_tdata[95:64]),
      .in_now     (req_tdata[127:96]),
      .in_ta      (req_tdata[143:128]),
      .in_claimed (req_tdata[151:144]),
      .rsp_tvalid,
      .rsp_tready,
      .rsp
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tdata = {
      1'b0, rsp.expired_count, rsp.echo_key, rsp.ta_value, rsp.ta_init,
      rsp.range_size, rsp.range_begin, rsp.entry_id
   };
endmodule
